>>> src/esms_pkg.sv
// Package for the endstop, sensor and motion sequencer: payload structs, register map,
// state and command codes, and reset values of the configuration registers.
// No dependencies; every other file imports it.
package esms_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int TIMER_BITS_DEF    = 24;

    localparam int CNT_W      = 16;
    localparam int TRAVEL_W   = 23;
    localparam int DELAY_W    = 24;
    localparam int POS_FIELD_W = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [CNT_W-1:0]    CNT_MAX           = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]    DEBOUNCE_RESET    = 16'd50;
    localparam logic [CNT_W-1:0]    SAMPLE_RESET      = 16'd100;
    localparam logic [CNT_W-1:0]    THRESHOLD_RESET   = 16'd1166;
    localparam logic [TRAVEL_W-1:0] TRAVEL_RESET      = 23'd2000;
    localparam logic [DELAY_W-1:0]  RELAY_DELAY_RESET = 24'd10000;

    typedef enum logic [2:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_SAMPLE      = 3'd1,
        REG_THRESHOLD   = 3'd2,
        REG_TRAVEL      = 3'd3,
        REG_RELAY_DELAY = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        SEQ_IDLE_HOME     = 3'd0,
        SEQ_MOVING_AWAY   = 3'd1,
        SEQ_IDLE_AWAY     = 3'd2,
        SEQ_MOVING_HOME   = 3'd3,
        SEQ_ENDSTOP_ERROR = 3'd4,
        SEQ_HOME_MISSING  = 3'd5,
        SEQ_GENERAL_ERROR = 3'd6
    } seq_state_t;

    typedef enum logic [2:0] {
        CMD_NONE         = 3'd0,
        CMD_MOVE_TRAVEL  = 3'd1,
        CMD_MOVE_ZERO    = 3'd2,
        CMD_STOP         = 3'd3,
        CMD_STOP_BACKOFF = 3'd4
    } motor_cmd_t;

    typedef struct packed {
        logic                          endstop_edge;
        logic [CNT_W-1:0]              echo_us;
        logic                          motion_running;
        logic signed [POS_FIELD_W-1:0] position;
    } tick_t;

    typedef struct packed {
        logic [2:0] seq_state;
        logic [2:0] motor_command;
        logic       drive_enable;
        logic       relay_on;
        logic       light_toggle;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]    debounce_ms;
        logic [CNT_W-1:0]    sample_period_ms;
        logic [CNT_W-1:0]    echo_threshold_us;
        logic [TRAVEL_W-1:0] travel_steps;
        logic [DELAY_W-1:0]  relay_delay_ms;
    } cfg_t;

endpackage

>>> src/esms_core.sv
// Sequencer core: timers, state register and the per-tick decision logic.
// The result of an accepted tick is formed combinationally; depends on esms_pkg.
module esms_core
    import esms_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  tick_t   tick,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CMP_W = (POSITION_BITS > TRAVEL_W ? POSITION_BITS : TRAVEL_W) + 1;
    localparam int TCMP_W = TIMER_BITS > DELAY_W ? TIMER_BITS : DELAY_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    seq_state_t            seq_reg, seq_next;
    logic [CNT_W-1:0]      since_endstop_reg, since_endstop_next;
    logic [CNT_W-1:0]      since_sample_reg, since_sample_next;
    logic [TIMER_BITS-1:0] relay_timer_reg, relay_timer_next;
    logic                  relay_done_reg, relay_done_next;
    logic                  relay_level_reg, relay_level_next;
    logic                  enable_level_reg, enable_level_next;

    logic [CNT_W-1:0]        endstop_inc, sample_inc;
    logic                    edge_ok, sample_ok, detect, issued, at_travel, relay_fire;
    logic [POS_FIELD_W-1:0]  pos_raw;
    logic [POSITION_BITS-1:0] pos_bits;
    logic signed [CMP_W-1:0] pos_ext, travel_ext;
    motor_cmd_t              cmd;

    assign endstop_inc = (since_endstop_reg == CNT_MAX) ? CNT_MAX : since_endstop_reg + 1'b1;
    assign sample_inc  = (since_sample_reg == CNT_MAX) ? CNT_MAX : since_sample_reg + 1'b1;

    assign edge_ok   = tick.endstop_edge
                     && ((endstop_inc == CNT_MAX) || (endstop_inc > cfg.debounce_ms));
    assign sample_ok = !edge_ok
                     && ((sample_inc == CNT_MAX) || (sample_inc > cfg.sample_period_ms));
    assign detect    = sample_ok && (tick.echo_us != '0)
                     && (tick.echo_us < cfg.echo_threshold_us);
    assign issued    = detect && ((seq_reg == SEQ_IDLE_HOME) || (seq_reg == SEQ_IDLE_AWAY));

    assign pos_raw    = tick.position;
    assign pos_bits   = POSITION_BITS'(pos_raw);
    assign pos_ext    = CMP_W'(signed'(pos_bits));
    assign travel_ext = signed'(CMP_W'(cfg.travel_steps));
    assign at_travel  = (pos_ext == travel_ext);

    assign relay_fire = !edge_ok && !relay_done_reg
                      && (TCMP_W'(relay_timer_reg) >= TCMP_W'(cfg.relay_delay_ms));

    assign since_endstop_next = edge_ok ? '0 : endstop_inc;
    assign since_sample_next  = sample_ok ? '0 : sample_inc;
    assign relay_timer_next   = (relay_timer_reg == TIMER_MAX) ? TIMER_MAX
                              : relay_timer_reg + 1'b1;
    assign relay_done_next    = relay_done_reg || relay_fire;

    always_comb
    begin
        seq_next = seq_reg;
        if (edge_ok)
        begin
            case (seq_reg)
                SEQ_MOVING_HOME: seq_next = SEQ_IDLE_HOME;
                SEQ_MOVING_AWAY: seq_next = SEQ_ENDSTOP_ERROR;
                SEQ_IDLE_HOME:   seq_next = SEQ_IDLE_HOME;
                SEQ_IDLE_AWAY:   seq_next = SEQ_IDLE_AWAY;
                default:         seq_next = SEQ_GENERAL_ERROR;
            endcase
        end
        else if (issued)
        begin
            seq_next = (seq_reg == SEQ_IDLE_HOME) ? SEQ_MOVING_AWAY : SEQ_MOVING_HOME;
        end
        else
        begin
            case (seq_reg)
                SEQ_MOVING_AWAY:
                begin
                    if (!tick.motion_running)
                    begin
                        seq_next = at_travel ? SEQ_IDLE_AWAY : SEQ_GENERAL_ERROR;
                    end
                end
                SEQ_MOVING_HOME:
                begin
                    if (!tick.motion_running)
                    begin
                        seq_next = SEQ_HOME_MISSING;
                    end
                end
                SEQ_IDLE_HOME, SEQ_IDLE_AWAY, SEQ_ENDSTOP_ERROR, SEQ_HOME_MISSING,
                SEQ_GENERAL_ERROR: seq_next = seq_reg;
                default: seq_next = SEQ_GENERAL_ERROR;
            endcase
        end
    end

    always_comb
    begin
        cmd               = CMD_NONE;
        enable_level_next = enable_level_reg;
        relay_level_next  = relay_level_reg;
        if (edge_ok)
        begin
            case (seq_reg)
                SEQ_MOVING_HOME:
                begin
                    cmd               = CMD_STOP_BACKOFF;
                    enable_level_next = 1'b0;
                    relay_level_next  = 1'b0;
                end
                SEQ_IDLE_HOME, SEQ_IDLE_AWAY: cmd = CMD_NONE;
                default:
                begin
                    cmd               = CMD_STOP;
                    enable_level_next = 1'b0;
                end
            endcase
        end
        else
        begin
            if (issued)
            begin
                cmd               = (seq_reg == SEQ_IDLE_HOME) ? CMD_MOVE_TRAVEL : CMD_MOVE_ZERO;
                enable_level_next = 1'b1;
            end
            else if (((seq_reg == SEQ_MOVING_AWAY) || (seq_reg == SEQ_MOVING_HOME))
                     && !tick.motion_running)
            begin
                enable_level_next = 1'b0;
                if ((seq_reg == SEQ_MOVING_AWAY) && at_travel)
                begin
                    relay_level_next = 1'b1;
                end
            end
            if (relay_fire)
            begin
                relay_level_next = 1'b1;
            end
        end
    end

    assign res.seq_state     = seq_next;
    assign res.motor_command = cmd;
    assign res.drive_enable  = enable_level_next;
    assign res.relay_on      = relay_level_next;
    assign res.light_toggle  = detect;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg           <= SEQ_IDLE_HOME;
            since_endstop_reg <= CNT_MAX;
            since_sample_reg  <= '0;
            relay_timer_reg   <= '0;
            relay_done_reg    <= 1'b0;
            relay_level_reg   <= 1'b0;
            enable_level_reg  <= 1'b0;
        end
        else if (accept)
        begin
            seq_reg           <= seq_next;
            since_endstop_reg <= since_endstop_next;
            since_sample_reg  <= since_sample_next;
            relay_timer_reg   <= relay_timer_next;
            relay_done_reg    <= relay_done_next;
            relay_level_reg   <= relay_level_next;
            enable_level_reg  <= enable_level_next;
        end
    end

endmodule

>>> src/endstop_sensor_motion_sequencer_top.sv
// Top level of the endstop, sensor and motion sequencer: register port, core and
// output skid stage. Depends on esms_pkg and esms_core.
//
//   Channel   Handshake                    Payload
//   tick      tick_valid / tick_ready      tick   (tick_t)
//   res       res_valid / res_ready        res    (result_t)
//   config    psel, penable, pwrite        paddr, pwdata, prdata
//
// One tick is accepted per cycle while tick_ready is high. The core's decision logic
// forms its result, which is registered in the output register. A stalled result is
// held and one more result fits in the skid register, so tick_ready falls only when
// both are full. Reset clears the state and loads the register defaults.
module endstop_sensor_motion_sequencer_top
    import esms_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  tick_t                 tick,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    reg_index_t reg_idx;
    logic       wr_en, accept, take;
    result_t    core_res, out_reg, skid_reg;
    logic       out_valid_reg, skid_valid_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_index_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= DEBOUNCE_RESET;
            cfg_reg.sample_period_ms  <= SAMPLE_RESET;
            cfg_reg.echo_threshold_us <= THRESHOLD_RESET;
            cfg_reg.travel_steps      <= TRAVEL_RESET;
            cfg_reg.relay_delay_ms    <= RELAY_DELAY_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEBOUNCE:    cfg_reg.debounce_ms       <= pwdata[CNT_W-1:0];
                REG_SAMPLE:      cfg_reg.sample_period_ms  <= pwdata[CNT_W-1:0];
                REG_THRESHOLD:   cfg_reg.echo_threshold_us <= pwdata[CNT_W-1:0];
                REG_TRAVEL:      cfg_reg.travel_steps      <= pwdata[TRAVEL_W-1:0];
                REG_RELAY_DELAY: cfg_reg.relay_delay_ms    <= pwdata[DELAY_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEBOUNCE:    prdata = APB_DATA_W'(cfg_reg.debounce_ms);
            REG_SAMPLE:      prdata = APB_DATA_W'(cfg_reg.sample_period_ms);
            REG_THRESHOLD:   prdata = APB_DATA_W'(cfg_reg.echo_threshold_us);
            REG_TRAVEL:      prdata = APB_DATA_W'(cfg_reg.travel_steps);
            REG_RELAY_DELAY: prdata = APB_DATA_W'(cfg_reg.relay_delay_ms);
            default:         prdata = '0;
        endcase
    end

    assign tick_ready = !skid_valid_reg;
    assign accept     = tick_valid && tick_ready;
    assign take       = out_valid_reg && res_ready;

    esms_core #(
        .POSITION_BITS (POSITION_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .tick   (tick),
        .cfg    (cfg_reg),
        .res    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= core_res;
            end
            else
            begin
                out_reg <= core_res;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> src/esms_checker.sv
// Port-level checker for the endstop, sensor and motion sequencer, bound to the top level.
// Depends on esms_pkg and on the top level's port list.
module esms_checker
    import esms_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    tick_valid,
    input logic    tick_ready,
    input logic    res_valid,
    input logic    res_ready,
    input result_t res
);

    // A result that is not taken stays on the port unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

    // Backpressure on ticks only appears while a result is waiting.
    a_ready_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> res_valid)
        else $error("tick_ready low with no pending result");

    // A tick transfer into an empty output gives a result in the next cycle.
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready && !res_valid) |=> res_valid)
        else $error("accepted tick produced no result");

    // The homing stop always lands at home with the driver and relay off.
    a_backoff_home: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.motor_command == CMD_STOP_BACKOFF))
        |-> ((res.seq_state == SEQ_IDLE_HOME) && !res.drive_enable && !res.relay_on))
        else $error("stop and back off outside homing completion");

endmodule

bind endstop_sensor_motion_sequencer_top esms_checker u_esms_checker (.*);
